### rtl/rms_pkg.sv
// ============================================================================
// rms_pkg - remote motor link supervisor package
// Shared types, codes and the mode transition function.
// ============================================================================
package rms_pkg;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned TIMEOUT_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEALTH_TIMEOUT = 8'd1;

    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST    = 24'd30000;
    localparam logic [TIMEOUT_W-1:0] HEALTH_TIMEOUT_RST = 24'd300000;

    // modes
    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_ON   = 3'd1;
    localparam logic [2:0] MODE_WAIT = 3'd2;
    localparam logic [2:0] MODE_DOWN = 3'd3;
    localparam logic [2:0] MODE_HOT  = 3'd4;

    // input actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_PING  = 2'd1;
    localparam logic [1:0] ACT_ACK   = 2'd2;
    localparam logic [1:0] ACT_OTHER = 2'd3;

    // acknowledge responses
    localparam logic [1:0] RESP_OK  = 2'd0;
    localparam logic [1:0] RESP_HOT = 2'd1;

    // command codes
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_ON   = 2'd1;
    localparam logic [1:0] SEND_OFF  = 2'd2;

    // alarm codes
    localparam logic [1:0] BEEP_NONE = 2'd0;
    localparam logic [1:0] BEEP_HOT  = 2'd1;
    localparam logic [1:0] BEEP_DOWN = 2'd2;

    localparam logic [7:0] LAMP_OFF  = 8'd0;
    localparam logic [7:0] LAMP_FULL = 8'd255;

    typedef struct packed {
        logic [1:0] action;
        logic       overheated;
        logic       motor_running;
        logic [1:0] response;
        logic       on_pressed;
        logic       off_pressed;
    } in_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
        logic       health_lamp;
        logic [1:0] send_command;
        logic [1:0] beep_start;
        logic       beep_stop;
        logic       restart;
    } out_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] ack_timeout_ticks;
        logic [TIMEOUT_W-1:0] health_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] beep;
    } mode_beep_t;

    // requested mode change, with the alarm it starts
    function automatic mode_beep_t enter_mode(logic [2:0] cur, logic [2:0] want);
        mode_beep_t r;
        r.mode = cur;
        r.beep = BEEP_NONE;
        if (want != cur) begin
            priority if (want == MODE_HOT) begin
                r.mode = MODE_HOT;
                r.beep = BEEP_HOT;
            end else if (want == MODE_DOWN) begin
                r.mode = MODE_DOWN;
                r.beep = BEEP_DOWN;
            end else if (want == MODE_WAIT && (cur == MODE_ON || cur == MODE_OFF)) begin
                r.mode = want;
            end else if (want == MODE_ON && (cur == MODE_OFF || cur == MODE_WAIT)) begin
                r.mode = want;
            end else if (want == MODE_OFF && (cur == MODE_ON || cur == MODE_WAIT)) begin
                r.mode = want;
            end else begin
                r.mode = cur;
            end
        end
        return r;
    endfunction

endpackage

### rtl/rms_cfg.sv
// ============================================================================
// rms_cfg - configuration registers
// Holds the acknowledge and health timeouts, written over the config channel.
// ============================================================================
module rms_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rms_pkg::TIMEOUT_W-1:0]       cfg_data,
    output rms_pkg::cfg_t                       cfg
);

    rms_pkg::cfg_t cfg_reg;
    rms_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            if (cfg_index == rms_pkg::CFG_ACK_TIMEOUT) begin
                cfg_next.ack_timeout_ticks = cfg_data;
            end else if (cfg_index == rms_pkg::CFG_HEALTH_TIMEOUT) begin
                cfg_next.health_timeout_ticks = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_timeout_ticks    <= rms_pkg::ACK_TIMEOUT_RST;
            cfg_reg.health_timeout_ticks <= rms_pkg::HEALTH_TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/rms_step.sv
// ============================================================================
// rms_step - per-item mode update
// Combinational next state and result for one registered input item.
// ============================================================================
module rms_step #(
    parameter int unsigned TIMER_WIDTH = 24
) (
    input  rms_pkg::in_t            item,
    input  rms_pkg::cfg_t           cfg,
    input  logic [2:0]              mode_cur,
    input  logic [TIMER_WIDTH-1:0]  ack_cur,
    input  logic [TIMER_WIDTH-1:0]  sil_cur,
    output logic [2:0]              mode_nxt,
    output logic [TIMER_WIDTH-1:0]  ack_nxt,
    output logic [TIMER_WIDTH-1:0]  sil_nxt,
    output rms_pkg::out_t           result
);

    localparam int unsigned CMP_W =
        (TIMER_WIDTH > rms_pkg::TIMEOUT_W) ? TIMER_WIDTH : rms_pkg::TIMEOUT_W;
    localparam logic [TIMER_WIDTH-1:0] CNT_MAX = {TIMER_WIDTH{1'b1}};

    logic [TIMER_WIDTH-1:0] ack_inc;
    logic [TIMER_WIDTH-1:0] sil_inc;
    logic [CMP_W-1:0]       ack_to_ext;
    logic [CMP_W-1:0]       health_to_ext;

    assign ack_inc       = (ack_cur == CNT_MAX) ? ack_cur : ack_cur + 1'b1;
    assign sil_inc       = (sil_cur == CNT_MAX) ? sil_cur : sil_cur + 1'b1;
    assign ack_to_ext    = CMP_W'(cfg.ack_timeout_ticks);
    assign health_to_ext = CMP_W'(cfg.health_timeout_ticks);

    always_comb begin
        rms_pkg::mode_beep_t    mb;
        logic [2:0]             m;
        logic [TIMER_WIDTH-1:0] a;
        logic [TIMER_WIDTH-1:0] s;
        logic [1:0]             send;
        logic [1:0]             beep;
        logic                   rst;

        m    = mode_cur;
        a    = ack_cur;
        s    = sil_cur;
        send = rms_pkg::SEND_NONE;
        beep = rms_pkg::BEEP_NONE;
        rst  = 1'b0;
        mb   = '0;

        if (item.action == rms_pkg::ACT_TICK) begin
            a = ack_inc;
            s = sil_inc;
            if (item.on_pressed && m == rms_pkg::MODE_OFF) begin
                mb   = rms_pkg::enter_mode(m, rms_pkg::MODE_WAIT);
                m    = mb.mode;
                send = rms_pkg::SEND_ON;
                a    = '0;
            end
            if (item.off_pressed && m == rms_pkg::MODE_ON) begin
                mb   = rms_pkg::enter_mode(m, rms_pkg::MODE_WAIT);
                m    = mb.mode;
                send = rms_pkg::SEND_OFF;
                a    = '0;
            end
            if (m == rms_pkg::MODE_WAIT && CMP_W'(a) > ack_to_ext) begin
                mb = rms_pkg::enter_mode(m, rms_pkg::MODE_DOWN);
                m  = mb.mode;
                if (mb.beep != rms_pkg::BEEP_NONE) begin
                    beep = mb.beep;
                end
            end
            if (CMP_W'(s) > health_to_ext) begin
                mb = rms_pkg::enter_mode(m, rms_pkg::MODE_DOWN);
                m  = mb.mode;
                if (mb.beep != rms_pkg::BEEP_NONE) begin
                    beep = mb.beep;
                end
            end
        end else begin
            if (item.action == rms_pkg::ACT_PING) begin
                if (m == rms_pkg::MODE_DOWN) begin
                    rst = 1'b1;
                end else if (item.overheated) begin
                    mb   = rms_pkg::enter_mode(m, rms_pkg::MODE_HOT);
                    m    = mb.mode;
                    beep = mb.beep;
                end else if (m == rms_pkg::MODE_HOT) begin
                    rst = 1'b1;
                end else begin
                    mb   = rms_pkg::enter_mode(m, item.motor_running ?
                                               rms_pkg::MODE_ON : rms_pkg::MODE_OFF);
                    m    = mb.mode;
                    beep = mb.beep;
                end
            end else if (item.action == rms_pkg::ACT_ACK && m == rms_pkg::MODE_WAIT) begin
                if (item.response == rms_pkg::RESP_OK) begin
                    mb   = rms_pkg::enter_mode(m, item.motor_running ?
                                               rms_pkg::MODE_ON : rms_pkg::MODE_OFF);
                    m    = mb.mode;
                    beep = mb.beep;
                end else if (item.response == rms_pkg::RESP_HOT) begin
                    mb   = rms_pkg::enter_mode(m, rms_pkg::MODE_HOT);
                    m    = mb.mode;
                    beep = mb.beep;
                end
            end
            s = '0;
            if (rst) begin
                m    = rms_pkg::MODE_OFF;
                a    = '0;
                beep = rms_pkg::BEEP_NONE;
            end
        end

        mode_nxt = m;
        ack_nxt  = a;
        sil_nxt  = s;

        result.mode         = m;
        result.led_red      = rms_pkg::LAMP_OFF;
        result.led_green    = rms_pkg::LAMP_OFF;
        result.led_blue     = rms_pkg::LAMP_OFF;
        result.health_lamp  = 1'b0;
        result.send_command = send;
        result.beep_start   = beep;
        result.beep_stop    = rst;
        result.restart      = rst;

        unique case (m)
            rms_pkg::MODE_ON: begin
                result.led_green   = rms_pkg::LAMP_FULL;
                result.health_lamp = 1'b1;
            end
            rms_pkg::MODE_WAIT: begin
                result.led_red     = rms_pkg::LAMP_FULL;
                result.led_green   = rms_pkg::LAMP_FULL;
                result.health_lamp = 1'b1;
            end
            rms_pkg::MODE_DOWN: begin
                result.led_red   = rms_pkg::LAMP_FULL;
                result.led_green = rms_pkg::LAMP_FULL;
            end
            rms_pkg::MODE_HOT: begin
                result.led_red = rms_pkg::LAMP_FULL;
            end
            default: begin
                result.led_red = rms_pkg::LAMP_OFF;
            end
        endcase
    end

endmodule

### rtl/remote_motor_link_supervisor.sv
// ============================================================================
// remote_motor_link_supervisor - master side of a remote motor link
// Mode, command and alarm control driven by button ticks and link messages.
// ============================================================================
// an item moves from the input register to the result register; one item per
// cycle while m_ready holds, set by the single input and result register
// the input register refills in the cycle its item moves to the result register
// reset: synchronous, active low; mode off, both tick counters zero,
// timeouts back to 30000 and 300000 ticks, both channels empty
module remote_motor_link_supervisor #(
    parameter int unsigned TIMER_WIDTH = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rms_pkg::TIMEOUT_W-1:0]   cfg_data,

    // item input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rms_pkg::in_t                    s_data,

    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output rms_pkg::out_t                   m_data
);

    // timeout registers
    rms_pkg::cfg_t cfg;

    rms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    logic         in_valid_reg;
    logic         in_valid_next;
    rms_pkg::in_t in_data_reg;

    // result register
    logic          out_valid_reg;
    logic          out_valid_next;
    rms_pkg::out_t out_data_reg;

    // supervisor state
    logic [2:0]             mode_reg;
    logic [TIMER_WIDTH-1:0] ack_reg;
    logic [TIMER_WIDTH-1:0] sil_reg;

    // step outputs
    logic [2:0]             mode_next;
    logic [TIMER_WIDTH-1:0] ack_next;
    logic [TIMER_WIDTH-1:0] sil_next;
    rms_pkg::out_t          result;

    logic advance;
    logic s_xfer;

    // the held item moves on when the result register is empty or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    rms_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .item     (in_data_reg),
        .cfg      (cfg),
        .mode_cur (mode_reg),
        .ack_cur  (ack_reg),
        .sil_cur  (sil_reg),
        .mode_nxt (mode_next),
        .ack_nxt  (ack_next),
        .sil_nxt  (sil_next),
        .result   (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // handshake and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= rms_pkg::MODE_OFF;
            ack_reg       <= '0;
            sil_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // state commits only when its item's result is taken into the output
            if (advance) begin
                mode_reg <= mode_next;
                ack_reg  <= ack_next;
                sil_reg  <= sil_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

### test/remote_motor_link_supervisor_tb.sv
// ============================================================================
// remote_motor_link_supervisor_tb - self-checking bench for the link supervisor
// Runs button ticks and link messages through the block under several timeout
// settings. A built-in predictor tracks mode, alarms and both tick counters,
// and every result transfer is checked field by field against it.
// ============================================================================
`timescale 1ns / 100ps

module remote_motor_link_supervisor_tb;

    import rms_pkg::*;

    localparam int CNT_W       = 24;   // tick counter width given to the block
    localparam int NUM_PHASES  = 8;    // timeout settings, directed phase first
    localparam int PHASE_ITEMS = 193;  // minimum random items per later phase
    localparam int HOLD_CYCLES = 200;  // long back-pressure stretch

    // one pending input transfer; pause asks the driver to wait for a full drain
    typedef struct {
        in_t item;
        bit  pause;
    } feed_t;

    // timeout settings per phase: extremes, zero, defaults and small values
    logic [TIMEOUT_W-1:0] ack_set [NUM_PHASES] =
        '{24'd2, 24'd1, 24'd0, 24'd5, 24'hFFFFFF, 24'd4, 24'd30000, 24'd3};
    logic [TIMEOUT_W-1:0] health_set [NUM_PHASES] =
        '{24'd3, 24'd1, 24'd6, 24'd0, 24'hFFFFFF, 24'd20, 24'd300000, 24'd9};

    // clock, reset and block ports; the bench-driven ones known from time zero
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIMEOUT_W-1:0] cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_t                  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_t                 m_data;

    // stimulus and expectation stores
    feed_t feed_q [$];
    out_t  status_due_q [$];

    // predictor state and its copy of the timeout registers
    logic [2:0]           sup_mode;
    logic [CNT_W-1:0]     ack_ticks;
    logic [CNT_W-1:0]     quiet_ticks;
    logic [TIMEOUT_W-1:0] ack_limit;
    logic [TIMEOUT_W-1:0] health_limit;

    // pacing controls shared between the sequence and the two channel processes
    logic in_taken       = 1'b0;
    bit   sender_idle_en = 1'b0;
    bit   recv_idle_en   = 1'b0;
    bit   long_hold_req  = 1'b0;
    bit   long_hold_done = 1'b0;
    int   gap_left       = 0;
    int   stall_left     = 0;
    int   hold_left      = 0;
    int   results_seen   = 0;
    int   fault_count    = 0;

    remote_motor_link_supervisor #(
        .TIMER_WIDTH (CNT_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // request a mode; returns the alarm that the change starts
    function automatic logic [1:0] move_to(input logic [2:0] target);
        logic [1:0] alarm;
        alarm = BEEP_NONE;
        if (target != sup_mode) begin
            case (target)
                MODE_HOT: begin
                    sup_mode = MODE_HOT;
                    alarm    = BEEP_HOT;
                end
                MODE_DOWN: begin
                    sup_mode = MODE_DOWN;
                    alarm    = BEEP_DOWN;
                end
                MODE_WAIT: begin
                    if (sup_mode == MODE_ON || sup_mode == MODE_OFF) sup_mode = target;
                end
                MODE_ON: begin
                    if (sup_mode == MODE_OFF || sup_mode == MODE_WAIT) sup_mode = target;
                end
                MODE_OFF: begin
                    if (sup_mode == MODE_ON || sup_mode == MODE_WAIT) sup_mode = target;
                end
                default: begin
                end
            endcase
        end
        return alarm;
    endfunction

    // advance the supervisor by one accepted item and build its status
    function automatic out_t supervise_step(input in_t it);
        out_t       res;
        logic [1:0] cmd;
        logic [1:0] alarm;
        logic [1:0] got;
        logic       reboot;
        cmd    = SEND_NONE;
        alarm  = BEEP_NONE;
        reboot = 1'b0;
        if (it.action == ACT_TICK) begin
            // both counters saturate at all ones
            if (ack_ticks != '1) ack_ticks = ack_ticks + 1'b1;
            if (quiet_ticks != '1) quiet_ticks = quiet_ticks + 1'b1;
            if (it.on_pressed && sup_mode == MODE_OFF) begin
                void'(move_to(MODE_WAIT));
                cmd       = SEND_ON;
                ack_ticks = '0;
            end
            if (it.off_pressed && sup_mode == MODE_ON) begin
                void'(move_to(MODE_WAIT));
                cmd       = SEND_OFF;
                ack_ticks = '0;
            end
            if (sup_mode == MODE_WAIT && ack_ticks > ack_limit) begin
                got = move_to(MODE_DOWN);
                if (got != BEEP_NONE) alarm = got;
            end
            if (quiet_ticks > health_limit) begin
                got = move_to(MODE_DOWN);
                if (got != BEEP_NONE) alarm = got;
            end
        end else begin
            if (it.action == ACT_PING) begin
                if (sup_mode == MODE_DOWN) begin
                    reboot = 1'b1;
                end else if (it.overheated) begin
                    alarm = move_to(MODE_HOT);
                end else if (sup_mode == MODE_HOT) begin
                    reboot = 1'b1;
                end else begin
                    alarm = move_to(it.motor_running ? MODE_ON : MODE_OFF);
                end
            end else if (it.action == ACT_ACK && sup_mode == MODE_WAIT) begin
                if (it.response == RESP_OK) begin
                    alarm = move_to(it.motor_running ? MODE_ON : MODE_OFF);
                end else if (it.response == RESP_HOT) begin
                    alarm = move_to(MODE_HOT);
                end
            end
            quiet_ticks = '0;
            if (reboot) begin
                sup_mode  = MODE_OFF;
                ack_ticks = '0;
                alarm     = BEEP_NONE;
            end
        end
        res              = '0;
        res.mode         = sup_mode;
        res.led_red      = LAMP_OFF;
        res.led_green    = LAMP_OFF;
        res.led_blue     = LAMP_OFF;
        res.health_lamp  = 1'b0;
        case (sup_mode)
            MODE_ON: begin
                res.led_green   = LAMP_FULL;
                res.health_lamp = 1'b1;
            end
            MODE_WAIT: begin
                res.led_red     = LAMP_FULL;
                res.led_green   = LAMP_FULL;
                res.health_lamp = 1'b1;
            end
            MODE_DOWN: begin
                res.led_red   = LAMP_FULL;
                res.led_green = LAMP_FULL;
            end
            MODE_HOT: begin
                res.led_red = LAMP_FULL;
            end
            default: begin
            end
        endcase
        res.send_command = cmd;
        res.beep_start   = alarm;
        res.beep_stop    = reboot;
        res.restart      = reboot;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // reporting
    // ------------------------------------------------------------------------

    // one line per mismatch
    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            flag_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                    results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // input driver: presents queued items at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : drive_items
        feed_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || in_taken) begin
            // the slot is free: either idle, hold off, or offer the next item
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (feed_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (feed_q[0].pause && status_due_q.size() != 0) begin
                // sender holds back until every outstanding result has arrived
                s_valid <= 1'b0;
            end else begin
                nxt     = feed_q.pop_front();
                s_data  <= nxt.item;
                s_valid <= 1'b1;
                // idle burst after this item, so gaps land on every mode
                if (sender_idle_en && $urandom_range(0, 9) == 0)
                    gap_left = $urandom_range(1, 16);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result ready pacing: random stalls plus one long back-pressure stretch
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : pace_results
        logic rdy;
        rdy = 1'b1;
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            // block fills up and must stall its input while we keep offering
            hold_left      = HOLD_CYCLES - 1;
            long_hold_done = 1'b1;
            rdy            = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (recv_idle_en && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 15);
            rdy        = 1'b0;
        end
        m_ready <= rdy;
    end

    // ------------------------------------------------------------------------
    // monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch_channels
        out_t want;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            // results first: a result never belongs to an item taken this edge
            if (m_valid && m_ready) begin
                results_seen++;
                if (status_due_q.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            results_seen));
                end else begin
                    want = status_due_q.pop_front();
                    check_field("mode", m_data.mode, want.mode);
                    check_field("led_red", m_data.led_red, want.led_red);
                    check_field("led_green", m_data.led_green, want.led_green);
                    check_field("led_blue", m_data.led_blue, want.led_blue);
                    check_field("health_lamp", m_data.health_lamp, want.health_lamp);
                    check_field("send_command", m_data.send_command, want.send_command);
                    check_field("beep_start", m_data.beep_start, want.beep_start);
                    check_field("beep_stop", m_data.beep_stop, want.beep_stop);
                    check_field("restart", m_data.restart, want.restart);
                end
            end
            if (s_valid && s_ready) status_due_q.push_back(supervise_step(s_data));
        end
    end

    // ------------------------------------------------------------------------
    // sequence helpers
    // ------------------------------------------------------------------------

    function automatic in_t make_item(input logic [1:0] act, input logic hot,
                                      input logic run, input logic [1:0] resp,
                                      input logic on_b, input logic off_b);
        in_t it;
        it.action        = act;
        it.overheated    = hot;
        it.motor_running = run;
        it.response      = resp;
        it.on_pressed    = on_b;
        it.off_pressed   = off_b;
        return it;
    endfunction

    function automatic void queue_item(input in_t it, input bit pause);
        feed_t f;
        f.item  = it;
        f.pause = pause;
        feed_q.push_back(f);
    endfunction

    // wait until nothing is queued, on the bus, outstanding or still idling,
    // then let the pipeline settle before touching the registers
    task automatic settle();
        @(posedge aclk);
        while (feed_q.size() != 0 || s_valid || status_due_q.size() != 0 ||
               gap_left != 0 || stall_left != 0 || hold_left != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write transfer; predictor copy updates at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [TIMEOUT_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_ACK_TIMEOUT) ack_limit = val;
        else if (idx == CFG_HEALTH_TIMEOUT) health_limit = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        int                   p;
        int                   n;
        int                   sel;
        int                   run_len;
        bit                   paused;
        in_t                  it;
        logic [$bits(in_t)-1:0] raw;

        // predictor starts from the reset state
        sup_mode     = MODE_OFF;
        ack_ticks    = '0;
        quiet_ticks  = '0;
        ack_limit    = ACK_TIMEOUT_RST;
        health_limit = HEALTH_TIMEOUT_RST;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (p = 0; p < NUM_PHASES; p++) begin
            // last phase runs flat out on both sides
            sender_idle_en = (p != NUM_PHASES - 1) && (p % 3 != 2);
            recv_idle_en   = (p != NUM_PHASES - 1) && (p % 3 != 1);
            if (p > 0) settle();
            write_reg(CFG_ACK_TIMEOUT, ack_set[p]);
            write_reg(CFG_HEALTH_TIMEOUT, health_set[p]);

            if (p == 0) begin
                // directed walk: ack timeout 2, health timeout 3
                queue_item(make_item(ACT_TICK, 1'b0, 1'b0, RESP_OK, 1'b1, 1'b0), 1'b0);
                queue_item(make_item(ACT_ACK, 1'b0, 1'b1, RESP_OK, 1'b0, 1'b0), 1'b0);
                queue_item(make_item(ACT_TICK, 1'b0, 1'b0, RESP_OK, 1'b0, 1'b1), 1'b0);
                queue_item(make_item(ACT_ACK, 1'b0, 1'b0, RESP_OK, 1'b0, 1'b0), 1'b0);
                // both buttons at once from off
                queue_item(make_item(ACT_TICK, 1'b0, 1'b0, RESP_OK, 1'b1, 1'b1), 1'b0);
                // unknown acknowledge codes leave waiting alone
                queue_item(make_item(ACT_ACK, 1'b0, 1'b1, 2'd2, 1'b0, 1'b0), 1'b0);
                queue_item(make_item(ACT_ACK, 1'b1, 1'b1, 2'd3, 1'b1, 1'b1), 1'b0);
                queue_item(make_item(ACT_ACK, 1'b0, 1'b0, RESP_HOT, 1'b0, 1'b0), 1'b0);
                // hot ping while hot, then a cool ping restarts
                queue_item(make_item(ACT_PING, 1'b1, 1'b0, RESP_OK, 1'b0, 1'b0), 1'b0);
                queue_item(make_item(ACT_PING, 1'b0, 1'b1, RESP_OK, 1'b0, 1'b0), 1'b0);
                // wait out the acknowledge timeout into link down
                queue_item(make_item(ACT_TICK, 1'b0, 1'b0, RESP_OK, 1'b1, 1'b0), 1'b0);
                repeat (3)
                    queue_item(make_item(ACT_TICK, 1'b0, 1'b0, RESP_OK, 1'b0, 1'b0), 1'b0);
                // any ping while down restarts, even a hot one
                queue_item(make_item(ACT_PING, 1'b1, 1'b1, RESP_OK, 1'b0, 1'b0), 1'b0);
                queue_item(make_item(ACT_PING, 1'b0, 1'b1, RESP_OK, 1'b0, 1'b0), 1'b0);
                queue_item(make_item(ACT_PING, 1'b0, 1'b0, RESP_OK, 1'b0, 1'b0), 1'b0);
                queue_item(make_item(ACT_OTHER, 1'b1, 1'b1, 2'd3, 1'b1, 1'b1), 1'b0);
                queue_item(make_item(ACT_PING, 1'b1, 1'b0, RESP_OK, 1'b0, 1'b0), 1'b0);
                // acknowledge outside waiting is ignored
                queue_item(make_item(ACT_ACK, 1'b0, 1'b1, RESP_OK, 1'b0, 1'b0), 1'b0);
                // silence past the health timeout takes hot to down
                repeat (4)
                    queue_item(make_item(ACT_TICK, 1'b0, 1'b0, RESP_OK, 1'b0, 1'b0), 1'b0);
                queue_item(make_item(ACT_TICK, 1'b1, 1'b1, 2'd3, 1'b1, 1'b1), 1'b0);
            end else begin
                n      = 0;
                // no drain pause in the flat-out phase
                paused = (p == NUM_PHASES - 1);
                while (n < PHASE_ITEMS) begin
                    sel = $urandom_range(0, 99);
                    raw = $urandom_range(0, (1 << $bits(in_t)) - 1);
                    it  = raw;
                    if (sel < 10) begin
                        // quiet stretch of ticks to reach the timeouts
                        run_len = $urandom_range(1, 24);
                        repeat (run_len) begin
                            raw            = $urandom_range(0, (1 << $bits(in_t)) - 1);
                            it             = raw;
                            it.action      = ACT_TICK;
                            it.on_pressed  = 1'b0;
                            it.off_pressed = 1'b0;
                            queue_item(it, n >= 60 && !paused);
                            if (n >= 60) paused = 1'b1;
                            n++;
                        end
                    end else begin
                        if (sel < 45) begin
                            it.action = ACT_TICK;
                        end else if (sel < 70) begin
                            it.action = ACT_ACK;
                            sel       = $urandom_range(0, 9);
                            if (sel < 6) it.response = RESP_OK;
                            else if (sel < 8) it.response = RESP_HOT;
                            else it.response = 2'($urandom_range(2, 3));
                        end else if (sel < 92) begin
                            it.action     = ACT_PING;
                            it.overheated = ($urandom_range(0, 6) == 0);
                        end else begin
                            it.action = ACT_OTHER;
                        end
                        queue_item(it, n >= 60 && !paused);
                        if (n >= 60) paused = 1'b1;
                        n++;
                    end
                end
                if (p == 3) long_hold_req = 1'b1;
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        if (status_due_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", status_due_q.size()));
        if (fault_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin : watchdog
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
rtl/rms_pkg.sv
rtl/rms_cfg.sv
rtl/rms_step.sv
rtl/remote_motor_link_supervisor.sv
test/remote_motor_link_supervisor_tb.sv
